[design/pidcf_pkg.sv]
// shared types, constants and microprogram for the pid core
`timescale 1ns / 1ps
`default_nettype none
package pidcf_pkg;

	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int INTEG_W    = 16;
	localparam int FRAC_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int STEP_W     = 4;

	localparam logic [GAIN_W-1:0] COEF_RESET  = 16'd39322;
	localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd3000;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FIRST = 4'd0;
	localparam step_t STEP_FIN   = 4'd9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_FILTER_COEF  = 3'd3,
		REG_INTEG_LIMIT  = 3'd4,
		REG_OUT_LIMIT    = 3'd5,
		REG_OUT_LIMIT_EN = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		MA_KI,
		MA_KP,
		MA_BETA,
		MA_KD
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_ERR,
		MB_DH,
		MB_DL,
		MB_HI,
		MB_LO
	} mul_b_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_INTEG,
		OP_SUM_INIT,
		OP_FILT_HI,
		OP_FILT_LO,
		OP_SUM_HI,
		OP_SUM_LO,
		OP_FINISH
	} alu_op_t;

	typedef struct packed {
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		alu_op_t op;
		logic    br_no_deriv;
		step_t   target;
	} ucode_t;

	typedef struct packed {
		logic    load;
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		alu_op_t op;
	} dp_ctrl_t;

	// microprogram: each step issues one product, and the integ, filter and sum steps consume the previous one
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			4'd0: w = '{MA_KI,   MB_ERR, OP_IDLE,     1'b0, STEP_FIN};
			4'd1: w = '{MA_KP,   MB_ERR, OP_INTEG,    1'b0, STEP_FIN};
			4'd2: w = '{MA_KI,   MB_ERR, OP_SUM_INIT, 1'b1, STEP_FIN};
			4'd3: w = '{MA_BETA, MB_DH,  OP_IDLE,     1'b0, STEP_FIN};
			4'd4: w = '{MA_BETA, MB_DL,  OP_FILT_HI,  1'b0, STEP_FIN};
			4'd5: w = '{MA_KI,   MB_ERR, OP_FILT_LO,  1'b0, STEP_FIN};
			4'd6: w = '{MA_KD,   MB_HI,  OP_IDLE,     1'b0, STEP_FIN};
			4'd7: w = '{MA_KD,   MB_LO,  OP_SUM_HI,   1'b0, STEP_FIN};
			4'd8: w = '{MA_KI,   MB_ERR, OP_SUM_LO,   1'b0, STEP_FIN};
			default: w = '{MA_KI, MB_ERR, OP_FINISH, 1'b0, STEP_FIN};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[design/pidcf_datapath.sv]
// shared multiplier, accumulators and loop state of the pid core
`timescale 1ns / 1ps
`default_nettype none
module pidcf_datapath #(
	parameter int DATA_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pidcf_pkg::dp_ctrl_t             ctrl,
	input  wire logic [DATA_WIDTH-1:0]           setpoint,
	input  wire logic [DATA_WIDTH-1:0]           measurement,
	input  wire logic [pidcf_pkg::GAIN_W-1:0]    prop_gain,
	input  wire logic [pidcf_pkg::GAIN_W-1:0]    integ_gain,
	input  wire logic [pidcf_pkg::GAIN_W-1:0]    deriv_gain,
	input  wire logic [pidcf_pkg::GAIN_W-1:0]    deriv_filter_coef,
	input  wire logic [pidcf_pkg::LIM_W-1:0]     integ_limit,
	input  wire logic [pidcf_pkg::LIM_W-1:0]     out_limit,
	input  wire logic                            out_limit_enable,
	output logic      [DATA_WIDTH-1:0]           drive
);
	import pidcf_pkg::*;

	localparam int EW   = DATA_WIDTH + 1;
	localparam int DERW = DATA_WIDTH + 2;
	localparam int FW   = DATA_WIDTH + 20;
	localparam int DW   = DATA_WIDTH + 20;
	localparam int MB   = (DATA_WIDTH + 4 > 17) ? DATA_WIDTH + 4 : 17;
	localparam int PW   = MB + GAIN_W + 1;
	localparam int SW   = PW + 3;

	localparam logic signed [PW-1:0] RND8     = 128;
	localparam logic signed [PW-1:0] RND16    = 32768;
	localparam logic signed [SW-1:0] SUM_RND8 = 128;
	localparam logic signed [SW-1:0] D_MAX    = {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] D_MIN    = ~D_MAX;

	logic signed [EW-1:0]      err_q;
	logic signed [EW-1:0]      prev_q;
	logic                      first_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [FW-1:0]      filt_q;
	logic signed [DW-1:0]      diff_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [SW-1:0]      sum_q;

	logic                      deriv_on;
	logic signed [EW-1:0]      err_c;
	logic signed [GAIN_W:0]    op_a;
	logic signed [MB-1:0]      op_b;
	logic signed [PW-1:0]      prod_c;
	logic signed [DW-FRAC_W-1:0] dh;
	logic signed [FW-FRAC_W-1:0] hi;
	logic signed [PW-1:0]      i_inc;
	logic signed [PW-1:0]      i_sum;
	logic signed [PW-1:0]      i_lim;
	logic signed [PW-1:0]      i_new;
	logic signed [DERW-1:0]    der;
	logic signed [FW-1:0]      f_start;
	logic signed [DW-1:0]      diff_c;
	logic signed [FW-1:0]      filt_hi;
	logic signed [FW-1:0]      filt_lo;
	logic signed [SW-1:0]      sum_init;
	logic signed [SW-1:0]      sum_hi;
	logic signed [SW-1:0]      sum_lo;
	logic signed [SW-1:0]      d_rnd;
	logic signed [SW-1:0]      o_lim;
	logic signed [SW-1:0]      d_clamp;
	logic signed [SW-1:0]      d_sat;

	assign deriv_on = (deriv_gain != '0);
	assign err_c    = EW'($signed(setpoint)) - EW'($signed(measurement));
	assign dh       = $signed(diff_q[DW-1:FRAC_W]);
	assign hi       = $signed(filt_q[FW-1:FRAC_W]);

	// shared multiplier operand select
	always_comb begin
		unique case (ctrl.mul_a)
			MA_KI:   op_a = $signed({1'b0, integ_gain});
			MA_KP:   op_a = $signed({1'b0, prop_gain});
			MA_BETA: op_a = $signed({1'b0, deriv_filter_coef});
			MA_KD:   op_a = $signed({1'b0, deriv_gain});
		endcase
		unique case (ctrl.mul_b)
			MB_ERR:  op_b = MB'(err_q);
			MB_DH:   op_b = MB'(dh);
			MB_DL:   op_b = MB'($signed({1'b0, diff_q[FRAC_W-1:0]}));
			MB_HI:   op_b = MB'(hi);
			MB_LO:   op_b = MB'($signed({1'b0, filt_q[FRAC_W-1:0]}));
			default: op_b = MB'(err_q);
		endcase
		prod_c = PW'(op_a) * PW'(op_b);
	end

	// integral update with symmetric clamp
	always_comb begin
		i_inc = (prod_q + RND8) >>> 8;
		i_sum = PW'(integ_q) + i_inc;
		i_lim = $signed(PW'(integ_limit));
		priority if (i_sum >= i_lim) begin
			i_new = i_lim;
		end else if (i_sum <= -i_lim) begin
			i_new = -i_lim;
		end else begin
			i_new = i_sum;
		end
	end

	// derivative filter and sum terms
	always_comb begin
		der      = first_q ? '0 : (DERW'(err_q) - DERW'(prev_q));
		f_start  = first_q ? '0 : filt_q;
		diff_c   = (DW'(der) <<< FRAC_W) - DW'(f_start);
		filt_hi  = filt_q + FW'(prod_q);
		filt_lo  = filt_q + FW'((prod_q + RND16) >>> FRAC_W);
		sum_init = (SW'(integ_q) <<< 8) + SW'(prod_q);
		sum_hi   = sum_q + SW'(prod_q);
		sum_lo   = sum_q + SW'(prod_q >>> FRAC_W);
	end

	// output rounding, clamp and saturation
	always_comb begin
		d_rnd = (sum_q + SUM_RND8) >>> 8;
		o_lim = $signed(SW'(out_limit));
		d_clamp = d_rnd;
		if (out_limit_enable) begin
			priority if (d_rnd >= o_lim) begin
				d_clamp = o_lim;
			end else if (d_rnd <= -o_lim) begin
				d_clamp = -o_lim;
			end else begin
				d_clamp = d_rnd;
			end
		end
		priority if (d_clamp > D_MAX) begin
			d_sat = D_MAX;
		end else if (d_clamp < D_MIN) begin
			d_sat = D_MIN;
		end else begin
			d_sat = d_clamp;
		end
		drive = DATA_WIDTH'(d_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			filt_q  <= '0;
			first_q <= 1'b1;
		end else begin
			unique case (ctrl.op)
				OP_INTEG: integ_q <= INTEG_W'(i_new);
				OP_SUM_INIT: begin
					if (deriv_on) begin
						prev_q  <= err_q;
						filt_q  <= f_start;
						first_q <= 1'b0;
					end
				end
				OP_FILT_HI: filt_q <= filt_hi;
				OP_FILT_LO: filt_q <= filt_lo;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		if (ctrl.load) begin
			err_q <= err_c;
		end
		unique case (ctrl.op)
			OP_SUM_INIT: begin
				sum_q <= sum_init;
				if (deriv_on) begin
					diff_q <= diff_c;
				end
			end
			OP_SUM_HI: sum_q <= sum_hi;
			OP_SUM_LO: sum_q <= sum_lo;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[design/pid_clamped_integral_filtered_derivative_core.sv]
// top level: stream ports, config registers and microcode sequencer of the pid core
// each beat runs the microprogram; with deriv_gain zero the derivative steps are skipped
// a new beat is taken only while idle or in the cycle the previous result is written out,
// so one sample finishes before the next; the ten-step program uses one multiplier
// results wait in an output register, so a stalled output delays only the finish step
// reset (arst_n low, asynchronous): registers return to their defaults, integral,
// previous error and filtered term clear, first-sample flag sets; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module pid_clamped_integral_filtered_derivative_core #(
	parameter int DATA_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// setpoint, measurement
	input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// drive
	output logic      [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [pidcf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [pidcf_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import pidcf_pkg::*;

	localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8;

	logic [GAIN_W-1:0]     prop_gain_q;
	logic [GAIN_W-1:0]     integ_gain_q;
	logic [GAIN_W-1:0]     deriv_gain_q;
	logic [GAIN_W-1:0]     filter_coef_q;
	logic [LIM_W-1:0]      integ_limit_q;
	logic [LIM_W-1:0]      out_limit_q;
	logic                  out_limit_en_q;

	logic                  busy_q;
	logic                  busy_d;
	step_t                 step_q;
	step_t                 step_d;
	logic                  m_valid_q;
	logic [DATA_WIDTH-1:0] drive_q;
	logic [DATA_WIDTH-1:0] dp_drive;

	ucode_t                ucode;
	dp_ctrl_t              dp_ctrl;
	logic                  in_fire;
	logic                  fin_go;

	assign cfg_ready     = 1'b1;
	assign ucode         = ucode_rom(step_q);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TW'(drive_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			filter_coef_q  <= COEF_RESET;
			integ_limit_q  <= LIMIT_RESET;
			out_limit_q    <= LIMIT_RESET;
			out_limit_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:    prop_gain_q    <= cfg_data;
				REG_INTEG_GAIN:   integ_gain_q   <= cfg_data;
				REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data;
				REG_FILTER_COEF:  filter_coef_q  <= cfg_data;
				REG_INTEG_LIMIT:  integ_limit_q  <= cfg_data[LIM_W-1:0];
				REG_OUT_LIMIT:    out_limit_q    <= cfg_data[LIM_W-1:0];
				REG_OUT_LIMIT_EN: out_limit_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next step
	always_comb begin
		busy_d = busy_q;
		step_d = step_q;
		priority if (in_fire) begin
			busy_d = 1'b1;
			step_d = STEP_FIRST;
		end else if (fin_go) begin
			busy_d = 1'b0;
		end else if (busy_q && ucode.op != OP_FINISH) begin
			if (ucode.br_no_deriv && deriv_gain_q == '0) begin
				step_d = ucode.target;
			end else begin
				step_d = step_q + 1'b1;
			end
		end else begin
			busy_d = busy_q;
		end
	end

	// sequencer outputs
	always_comb begin
		fin_go        = busy_q && ucode.op == OP_FINISH && (!m_valid_q || m_axis_tready);
		s_axis_tready = !busy_q || fin_go;
		dp_ctrl.load  = s_axis_tvalid && (!busy_q || fin_go);
		dp_ctrl.mul_a = ucode.mul_a;
		dp_ctrl.mul_b = ucode.mul_b;
		dp_ctrl.op    = busy_q ? ucode.op : OP_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= STEP_FIRST;
			m_valid_q <= 1'b0;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
			if (fin_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			drive_q <= dp_drive;
		end
	end

	pidcf_datapath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (dp_ctrl),
		.setpoint         (s_axis_tdata[DATA_WIDTH-1:0]),
		.measurement      (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.prop_gain        (prop_gain_q),
		.integ_gain       (integ_gain_q),
		.deriv_gain       (deriv_gain_q),
		.deriv_filter_coef(filter_coef_q),
		.integ_limit      (integ_limit_q),
		.out_limit        (out_limit_q),
		.out_limit_enable (out_limit_en_q),
		.drive            (dp_drive)
	);

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_FIN)
		else $error("step counter past end of program");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> busy_q && step_q == STEP_FIRST)
		else $error("accepted beat did not start the program");

	a_skip_deriv: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !in_fire && ucode.br_no_deriv && deriv_gain_q == '0 |=> step_q == STEP_FIN)
		else $error("derivative steps not skipped with zero gain");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> m_axis_tvalid)
		else $error("finished result not presented");

endmodule
`default_nettype wire

[verif/pid_clamped_integral_filtered_derivative_core_tb.sv]
// testbench for the pid core: directed and random samples checked against a drive predictor
`timescale 1ns / 1ps
module pid_clamped_integral_filtered_derivative_core_tb;
	import pidcf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;

	class pid_drive_model;
		logic [15:0] kp, ki, kd, beta;
		logic [14:0] ilim, olim;
		logic olim_en;
		logic signed [15:0] integ;
		logic signed [16:0] prev_err;
		logic signed [33:0] filt;
		logic first_pending;
		logic signed [15:0] drive_due[$];
		int mismatches;
		int checked;

		function new();
			kp = 0;
			ki = 0;
			kd = 0;
			beta = COEF_RESET;
			ilim = LIMIT_RESET;
			olim = LIMIT_RESET;
			olim_en = 1'b1;
			integ = 0;
			prev_err = 0;
			filt = 0;
			first_pending = 1'b1;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				REG_PROP_GAIN: kp = val;
				REG_INTEG_GAIN: ki = val;
				REG_DERIV_GAIN: kd = val;
				REG_FILTER_COEF: beta = val;
				REG_INTEG_LIMIT: ilim = val[14:0];
				REG_OUT_LIMIT: olim = val[14:0];
				REG_OUT_LIMIT_EN: olim_en = val[0];
				default: ;
			endcase
		endfunction

		function longint clamp_sym(longint x, longint lim);
			if (x >= lim) x = lim;
			if (x <= -lim) x = -lim;
			return x;
		endfunction

		function int pending();
			return drive_due.size();
		endfunction

		function void take_sample(logic signed [15:0] sp, logic signed [15:0] ms);
			longint err, acc, sum8, der, diff, dh, dl, f, hi, lo, drv;
			err = longint'(sp) - longint'(ms);
			acc = longint'(integ) + ((longint'(ki) * err + 128) >>> 8);
			acc = clamp_sym(acc, longint'(ilim));
			integ = 16'(acc);
			sum8 = acc * 256 + longint'(kp) * err;
			if (kd != 0) begin
				if (first_pending) begin
					filt = 0;
					der = 0;
				end else begin
					der = err - longint'(prev_err);
				end
				prev_err = 17'(err);
				first_pending = 1'b0;
				f = longint'(filt);
				diff = der * 65536 - f;
				dh = diff >>> 16;
				dl = longint'(diff[15:0]);
				f = f + longint'(beta) * dh + ((longint'(beta) * dl + 32768) >>> 16);
				filt = 34'(f);
				hi = f >>> 16;
				lo = longint'(f[15:0]);
				sum8 = sum8 + longint'(kd) * hi + ((longint'(kd) * lo) >>> 16);
			end
			drv = (sum8 + 128) >>> 8;
			if (olim_en) drv = clamp_sym(drv, longint'(olim));
			if (drv > 32767) drv = 32767;
			if (drv < -32768) drv = -32768;
			drive_due.push_back(16'(drv));
		endfunction

		function void check_drive(logic signed [15:0] got);
			logic signed [15:0] want;
			checked++;
			if (drive_due.size() == 0) begin
				$error("drive: expected nothing, got %0d", got);
				mismatches++;
				return;
			end
			want = drive_due.pop_front();
			if (got !== want) begin
				$error("drive: expected %0d, got %0d", want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pid_drive_model drive_model = new();
	int burst_left = 0;
	int samples_sent = 0;
	int settings_used = 0;
	int rx_hold = 0;
	int idle_cycles;

	pid_clamped_integral_filtered_derivative_core #(.DATA_WIDTH(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_sample(logic signed [15:0] sp, logic signed [15:0] ms);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ms, sp};
		do @(posedge clk); while (!s_axis_tready);
		drive_model.take_sample(sp, ms);
		burst_left--;
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (drive_model.pending() != 0);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		settings_used++;
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		drive_model.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 16'h03FF));
			3: return 16'($urandom_range(0, 16'hFFFF));
			default: return 16'($urandom_range(0, 16'h003F));
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		logic [14:0] lim;
		case ($urandom_range(0, 4))
			0: lim = 15'd0;
			1: lim = 15'h7FFF;
			2: lim = 15'($urandom_range(0, 500));
			3: lim = LIMIT_RESET;
			default: lim = 15'($urandom_range(0, 32767));
		endcase
		return {1'($urandom_range(0, 1)), lim};
	endfunction

	// output side stall pattern
	initial begin
		int mode, left, phase;
		logic [7:0] mask;
		mode = 0;
		left = 0;
		phase = 0;
		mask = 8'hA5;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 300);
					mask = 8'($urandom);
				end
				left--;
				phase++;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= mask[phase % 8];
					default: m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial forever begin
		@(posedge clk);
		if (m_axis_tvalid && m_axis_tready) drive_model.check_drive(m_axis_tdata);
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic signed [15:0] corner [5];
		logic signed [15:0] sp, ms, track_sp, track_ms;
		int r;
		corner = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
		track_sp = 0;
		track_ms = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults after reset, derivative off so the first-sample flag survives
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(0, 0);

		// derivative on: first sample, then the largest swings
		settle();
		set_reg(REG_PROP_GAIN, 16'h0100);
		set_reg(REG_INTEG_GAIN, 16'h0080);
		set_reg(REG_DERIV_GAIN, 16'h0300);
		set_reg(REG_INTEG_LIMIT, 16'd100);
		set_reg(REG_OUT_LIMIT, 16'd2000);
		set_reg(REG_OUT_LIMIT_EN, 16'd1);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(0, 0);
		send_sample(1, 0);
		send_sample(0, 1);
		send_sample(0, -1);
		send_sample(100, -100);

		// derivative off holds its state, then back on
		settle();
		set_reg(REG_DERIV_GAIN, 16'h0000);
		send_sample(500, 0);
		send_sample(-500, 0);
		settle();
		set_reg(REG_DERIV_GAIN, 16'h0100);
		send_sample(0, 0);
		send_sample(2000, 0);

		// zero limits, and a write to an unused index
		settle();
		set_reg(REG_INTEG_LIMIT, 16'd0);
		set_reg(REG_OUT_LIMIT, 16'd0);
		set_reg(REG_UNUSED, 16'hFFFF);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);

		// full gains, masked limits, clamp off: plain saturation
		settle();
		set_reg(REG_PROP_GAIN, 16'hFFFF);
		set_reg(REG_INTEG_GAIN, 16'hFFFF);
		set_reg(REG_DERIV_GAIN, 16'hFFFF);
		set_reg(REG_FILTER_COEF, 16'hFFFF);
		set_reg(REG_INTEG_LIMIT, 16'hFFFF);
		set_reg(REG_OUT_LIMIT, 16'hFFFF);
		set_reg(REG_OUT_LIMIT_EN, 16'hFFFE);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(1, 0);
		send_sample(0, 0);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			if (ph == 0) begin
				set_reg(REG_PROP_GAIN, 16'hFFFF);
				set_reg(REG_INTEG_GAIN, 16'hFFFF);
				set_reg(REG_DERIV_GAIN, 16'hFFFF);
				set_reg(REG_FILTER_COEF, 16'hFFFF);
				set_reg(REG_INTEG_LIMIT, 16'h7FFF);
				set_reg(REG_OUT_LIMIT, 16'h7FFF);
				set_reg(REG_OUT_LIMIT_EN, 16'd1);
			end else if (ph == 1) begin
				set_reg(REG_PROP_GAIN, 16'h0001);
				set_reg(REG_INTEG_GAIN, 16'h0001);
				set_reg(REG_DERIV_GAIN, 16'h0001);
				set_reg(REG_FILTER_COEF, 16'h0000);
				set_reg(REG_INTEG_LIMIT, 16'h7FFF);
				set_reg(REG_OUT_LIMIT, 16'h0000);
				set_reg(REG_OUT_LIMIT_EN, 16'd0);
			end else begin
				set_reg(REG_PROP_GAIN, pick_gain());
				set_reg(REG_INTEG_GAIN, pick_gain());
				set_reg(REG_DERIV_GAIN, pick_gain());
				set_reg(REG_FILTER_COEF, ($urandom_range(0, 2) == 0) ? 16'hFFFF :
					16'($urandom_range(0, 16'hFFFF)));
				set_reg(REG_INTEG_LIMIT, pick_limit());
				set_reg(REG_OUT_LIMIT, pick_limit());
				set_reg(REG_OUT_LIMIT_EN, 16'($urandom_range(0, 16'hFFFF)));
				if ($urandom_range(0, 2) == 0) set_reg(REG_UNUSED, 16'($urandom));
			end
			for (int i = 0; i < 230; i++) begin
				if (i == 60 && ph % 2 == 0) rx_hold = 400;
				if (i == 150) drain();
				r = $urandom_range(0, 19);
				if (r < 10) begin
					// closed-loop style: slow setpoint, wandering measurement
					if ($urandom_range(0, 31) == 0) track_sp = 16'($urandom);
					track_ms = track_ms + 16'(int'($urandom_range(0, 128)) - 64);
					sp = track_sp;
					ms = track_ms;
				end else if (r < 15) begin
					sp = 16'($urandom);
					ms = 16'($urandom);
				end else if (r < 17) begin
					sp = corner[$urandom_range(0, 4)];
					ms = corner[$urandom_range(0, 4)];
				end else begin
					sp = 16'(int'($urandom_range(0, 600)) - 300);
					ms = 16'(int'($urandom_range(0, 600)) - 300);
				end
				send_sample(sp, ms);
			end
		end

		settle();
		$display("covered %0d samples over %0d register settings, %0d drive beats checked",
			samples_sent, settings_used, drive_model.checked);
		if (drive_model.mismatches == 0 && drive_model.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
design/pidcf_pkg.sv
design/pidcf_datapath.sv
design/pid_clamped_integral_filtered_derivative_core.sv
verif/pid_clamped_integral_filtered_derivative_core_tb.sv
